FILE: rtl/pesf_pkg.sv
package pesf_pkg;

  // Fixed-point format shared by inputs and results.
  localparam int FRAC    = 14;
  localparam int IN_W    = 16;
  localparam int VAL_W   = 19;
  localparam int NODE_W  = 4;
  localparam int ET_W    = 2;
  localparam int SQ_W    = 2 * IN_W - 1;
  localparam int KAP_W   = IN_W + 3;
  localparam int FW      = 34;
  localparam int PW      = 2 * FW;
  localparam int QUAD_SH = 3 * FRAC + 2;
  localparam int NQ      = 6;

  // Element types.
  localparam logic [ET_W-1:0] ET_TRI3  = 2'd0;
  localparam logic [ET_W-1:0] ET_QUAD4 = 2'd1;
  localparam logic [ET_W-1:0] ET_TRI6  = 2'd2;
  localparam logic [ET_W-1:0] ET_QUAD9 = 2'd3;

  // Rounding shift classes.
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_FRAC = 2'd1;
  localparam logic [1:0] SH_QUAD = 2'd2;

  // One-dimensional factor kinds: linear minus/plus, quadratic minus/zero/plus.
  localparam logic [2:0] K_LM = 3'd0;
  localparam logic [2:0] K_LP = 3'd1;
  localparam logic [2:0] K_QM = 3'd2;
  localparam logic [2:0] K_QZ = 3'd3;
  localparam logic [2:0] K_QP = 3'd4;

  localparam logic [2:0] QUAD4_KX [4] = '{K_LM, K_LP, K_LP, K_LM};
  localparam logic [2:0] QUAD4_KY [4] = '{K_LM, K_LM, K_LP, K_LP};
  localparam logic [2:0] QUAD9_KX [9] = '{K_QM, K_QP, K_QP, K_QM, K_QZ, K_QP, K_QZ, K_QM, K_QZ};
  localparam logic [2:0] QUAD9_KY [9] = '{K_QM, K_QM, K_QP, K_QP, K_QM, K_QZ, K_QP, K_QZ, K_QZ};

  localparam logic signed [FW-1:0] ONE  = FW'(1);
  localparam logic signed [FW-1:0] UNIT = ONE <<< FRAC;
  localparam logic signed [FW-1:0] USQ  = UNIT <<< FRAC;

  localparam logic signed [PW:0] SAT_MAX = (PW+1)'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
  localparam logic signed [PW:0] SAT_MIN = -(PW+1)'(64'sd1 <<< (VAL_W - 1));

  // Point as it waits between front and back.
  typedef struct packed {
    logic [ET_W-1:0]          et;
    logic signed [IN_W-1:0]   x;
    logic signed [IN_W-1:0]   y;
    logic [SQ_W-1:0]          x2;
    logic [SQ_W-1:0]          y2;
    logic signed [KAP_W-1:0]  kap;
  } pt_ent_t;

  // A 1-D factor and its first and second derivative, over 2*U^2.
  typedef struct packed {
    logic signed [FW-1:0] d0;
    logic signed [FW-1:0] d1;
    logic signed [FW-1:0] d2;
  } fac_t;

  typedef struct packed {
    logic                    sat;
    logic signed [VAL_W-1:0] v;
  } rnd_t;

  function automatic logic [NODE_W-1:0] node_count(input logic [ET_W-1:0] et);
    logic [NODE_W-1:0] c;
    unique case (et)
      ET_TRI3:  c = NODE_W'(3);
      ET_QUAD4: c = NODE_W'(4);
      ET_TRI6:  c = NODE_W'(6);
      default:  c = NODE_W'(9);
    endcase
    return c;
  endfunction

  function automatic fac_t factor(input logic [2:0] k, input logic signed [IN_W-1:0] c,
                                  input logic [SQ_W-1:0] c2);
    logic signed [FW-1:0] xc;
    logic signed [FW-1:0] sq;
    logic signed [FW-1:0] xs;
    fac_t f;
    xc = FW'(c);
    sq = $signed({{(FW-SQ_W){1'b0}}, c2});
    xs = xc <<< FRAC;
    unique case (k)
      K_LM: begin
        f.d0 = (UNIT - xc) <<< FRAC;
        f.d1 = -USQ;
        f.d2 = '0;
      end
      K_LP: begin
        f.d0 = (UNIT + xc) <<< FRAC;
        f.d1 = USQ;
        f.d2 = '0;
      end
      K_QM: begin
        f.d0 = sq - xs;
        f.d1 = ((xc <<< 1) - UNIT) <<< FRAC;
        f.d2 = USQ <<< 1;
      end
      K_QZ: begin
        f.d0 = (USQ - sq) <<< 1;
        f.d1 = -(xs <<< 2);
        f.d2 = -(USQ <<< 2);
      end
      default: begin
        f.d0 = sq + xs;
        f.d1 = ((xc <<< 1) + UNIT) <<< FRAC;
        f.d2 = USQ <<< 1;
      end
    endcase
    return f;
  endfunction

  // Round half upward by the given shift class, then saturate.
  function automatic rnd_t round_sat(input logic signed [PW-1:0] p, input logic [1:0] sh);
    logic signed [PW:0] s;
    logic signed [PW:0] r;
    rnd_t o;
    s = $signed({p[PW-1], p});
    unique case (sh)
      SH_NONE: r = s;
      SH_FRAC: r = (s + ((PW+1)'(1) <<< (FRAC - 1))) >>> FRAC;
      default: r = (s + ((PW+1)'(1) <<< (QUAD_SH - 1))) >>> QUAD_SH;
    endcase
    if (r > SAT_MAX) begin
      o.sat = 1'b1;
      o.v   = SAT_MAX[VAL_W-1:0];
    end else if (r < SAT_MIN) begin
      o.sat = 1'b1;
      o.v   = SAT_MIN[VAL_W-1:0];
    end else begin
      o.sat = 1'b0;
      o.v   = r[VAL_W-1:0];
    end
    return o;
  endfunction

endpackage

FILE: rtl/pesf_ifs.sv
// Point channel: one natural-coordinate point per transfer.
interface pesf_point_if;
  import pesf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [IN_W-1:0] xi;
  logic signed [IN_W-1:0] eta;
  modport source (output valid, xi, eta, input ready);
  modport sink (input valid, xi, eta, output ready);
endinterface

// Result channel: one node's values per transfer.
interface pesf_result_if;
  import pesf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [NODE_W-1:0]       node_index;
  logic signed [VAL_W-1:0] shape_value;
  logic signed [VAL_W-1:0] d_dxi;
  logic signed [VAL_W-1:0] d2_dxi2;
  logic signed [VAL_W-1:0] d_deta;
  logic signed [VAL_W-1:0] d2_deta2;
  logic signed [VAL_W-1:0] d2_dxi_deta;
  logic                    saturated;
  logic                    last_node;
  modport source (output valid, node_index, shape_value, d_dxi, d2_dxi2, d_deta, d2_deta2,
                  d2_dxi_deta, saturated, last_node, input ready);
  modport sink (input valid, node_index, shape_value, d_dxi, d2_dxi2, d_deta, d2_deta2,
                d2_dxi_deta, saturated, last_node, output ready);
endinterface

FILE: rtl/pesf_front.sv
module pesf_front (
  input  logic                      clk,
  input  logic                      rst,
  pesf_point_if.sink                point,
  input  logic [pesf_pkg::ET_W-1:0] element_type,
  input  logic                      q_full,
  output logic                      push,
  output pesf_pkg::pt_ent_t         ent
);
  import pesf_pkg::*;

  logic             f_valid;
  pt_ent_t          f_ent;
  pt_ent_t          ent_next;
  logic signed [2*IN_W-1:0] xsq;
  logic signed [2*IN_W-1:0] ysq;

  // Classify the point: squares and the third triangle coordinate.
  always_comb begin
    xsq          = point.xi * point.xi;
    ysq          = point.eta * point.eta;
    ent_next.et  = element_type;
    ent_next.x   = point.xi;
    ent_next.y   = point.eta;
    ent_next.x2  = xsq[SQ_W-1:0];
    ent_next.y2  = ysq[SQ_W-1:0];
    ent_next.kap = KAP_W'(UNIT) - KAP_W'(point.xi) - KAP_W'(point.eta);
  end

  assign push        = f_valid && !q_full;
  assign point.ready = !f_valid || !q_full;
  assign ent         = f_ent;

  // Holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (point.valid && point.ready) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (point.valid && point.ready) begin
      f_ent <= ent_next;
    end
  end

endmodule

FILE: rtl/pesf_fifo.sv
module pesf_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pesf_pkg::pt_ent_t wdata,
  output logic              full,
  output logic              q_valid,
  input  logic              pop,
  output pesf_pkg::pt_ent_t rdata
);
  import pesf_pkg::*;

  pt_ent_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: rtl/pesf_back.sv
module pesf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  pesf_pkg::pt_ent_t head,
  output logic              pop,
  pesf_result_if.source     result
);
  import pesf_pkg::*;

  logic [NODE_W-1:0] n;
  logic              last;
  logic              adv;

  logic signed [FW-1:0] a_sel [NQ];
  logic signed [FW-1:0] b_sel [NQ];
  logic [1:0]           s_sel [NQ];
  logic [2:0]           kx;
  logic [2:0]           ky;
  fac_t                 fx;
  fac_t                 fy;
  logic signed [FW-1:0] xw;
  logic signed [FW-1:0] yw;
  logic signed [FW-1:0] kw;

  logic                 sa_valid;
  logic signed [FW-1:0] sa_a [NQ];
  logic signed [FW-1:0] sa_b [NQ];
  logic [1:0]           sa_s [NQ];
  logic [NODE_W-1:0]    sa_n;
  logic                 sa_last;

  logic                 sb_valid;
  logic signed [PW-1:0] sb_p [NQ];
  logic [1:0]           sb_s [NQ];
  logic [NODE_W-1:0]    sb_n;
  logic                 sb_last;

  rnd_t                 rq [NQ];
  logic                 any_sat;

  assign last = (n == node_count(head.et) - NODE_W'(1));
  assign adv  = !result.valid || result.ready;
  assign pop  = adv && q_valid && last;

  // Operand selection for the current node.
  always_comb begin
    xw = FW'(head.x);
    yw = FW'(head.y);
    kw = FW'(head.kap);
    if (head.et == ET_QUAD4) begin
      kx = QUAD4_KX[n[1:0]];
      ky = QUAD4_KY[n[1:0]];
    end else begin
      kx = QUAD9_KX[n];
      ky = QUAD9_KY[n];
    end
    fx = factor(kx, head.x, head.x2);
    fy = factor(ky, head.y, head.y2);
    for (int j = 0; j < NQ; j++) begin
      a_sel[j] = '0;
      b_sel[j] = ONE;
      s_sel[j] = SH_NONE;
    end
    unique case (head.et)
      ET_TRI3: begin
        unique case (n)
          NODE_W'(0): begin
            a_sel[0] = kw; a_sel[1] = -UNIT; a_sel[3] = -UNIT;
          end
          NODE_W'(1): begin
            a_sel[0] = xw; a_sel[1] = UNIT;
          end
          default: begin
            a_sel[0] = yw; a_sel[3] = UNIT;
          end
        endcase
      end
      ET_TRI6: begin
        s_sel[0] = SH_FRAC;
        unique case (n)
          NODE_W'(0): begin
            a_sel[0] = xw; b_sel[0] = (xw <<< 1) - UNIT;
            a_sel[1] = (xw <<< 2) - UNIT;
            a_sel[2] = UNIT <<< 2;
          end
          NODE_W'(1): begin
            a_sel[0] = yw; b_sel[0] = (yw <<< 1) - UNIT;
            a_sel[3] = (yw <<< 2) - UNIT;
            a_sel[4] = UNIT <<< 2;
          end
          NODE_W'(2): begin
            a_sel[0] = kw; b_sel[0] = (kw <<< 1) - UNIT;
            a_sel[1] = UNIT - (kw <<< 2);
            a_sel[3] = UNIT - (kw <<< 2);
            a_sel[2] = UNIT <<< 2; a_sel[4] = UNIT <<< 2; a_sel[5] = UNIT <<< 2;
          end
          NODE_W'(3): begin
            a_sel[0] = xw <<< 2; b_sel[0] = yw;
            a_sel[1] = yw <<< 2; a_sel[3] = xw <<< 2;
            a_sel[5] = UNIT <<< 2;
          end
          NODE_W'(4): begin
            a_sel[0] = yw <<< 2; b_sel[0] = kw;
            a_sel[1] = -(yw <<< 2); a_sel[3] = (kw - yw) <<< 2;
            a_sel[4] = -(UNIT <<< 3); a_sel[5] = -(UNIT <<< 2);
          end
          default: begin
            a_sel[0] = kw <<< 2; b_sel[0] = xw;
            a_sel[1] = (kw - xw) <<< 2; a_sel[3] = -(xw <<< 2);
            a_sel[2] = -(UNIT <<< 3); a_sel[5] = -(UNIT <<< 2);
          end
        endcase
      end
      default: begin
        a_sel[0] = fx.d0; b_sel[0] = fy.d0;
        a_sel[1] = fx.d1; b_sel[1] = fy.d0;
        a_sel[2] = fx.d2; b_sel[2] = fy.d0;
        a_sel[3] = fx.d0; b_sel[3] = fy.d1;
        a_sel[4] = fx.d0; b_sel[4] = fy.d2;
        a_sel[5] = fx.d1; b_sel[5] = fy.d1;
        for (int j = 0; j < NQ; j++) begin
          s_sel[j] = SH_QUAD;
        end
      end
    endcase
  end

  // Node counter walks the nodes of the head point.
  always_ff @(posedge clk) begin
    if (rst) begin
      n        <= '0;
      sa_valid <= 1'b0;
      sb_valid <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      sa_valid     <= q_valid;
      sb_valid     <= sa_valid;
      result.valid <= sb_valid;
      if (q_valid) begin
        n <= last ? '0 : n + NODE_W'(1);
      end
    end
  end

  // Rounding and saturation of the products.
  always_comb begin
    any_sat = 1'b0;
    for (int j = 0; j < NQ; j++) begin
      rq[j]   = round_sat(sb_p[j], sb_s[j]);
      any_sat = any_sat | rq[j].sat;
    end
  end

  // Operand, product and result registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      sa_n    <= n;
      sa_last <= last;
      sb_n    <= sa_n;
      sb_last <= sa_last;
      for (int j = 0; j < NQ; j++) begin
        sa_a[j] <= a_sel[j];
        sa_b[j] <= b_sel[j];
        sa_s[j] <= s_sel[j];
        sb_p[j] <= sa_a[j] * sa_b[j];
        sb_s[j] <= sa_s[j];
      end
      result.node_index  <= sb_n;
      result.last_node   <= sb_last;
      result.saturated   <= any_sat;
      result.shape_value <= rq[0].v;
      result.d_dxi       <= rq[1].v;
      result.d2_dxi2     <= rq[2].v;
      result.d_deta      <= rq[3].v;
      result.d2_deta2    <= rq[4].v;
      result.d2_dxi_deta <= rq[5].v;
    end
  end

endmodule

FILE: rtl/planar_element_shape_functions.sv
// Path: a point passes the front holding register and the queue, then the
// operand, product and result registers of the back end. Throughput: one node
// result per cycle unless the result channel stalls; a point gives 3, 4, 6 or 9 nodes.
// A two-entry queue lets the front take the next point while nodes drain.
// Synchronous reset empties the pipeline and sets element_type to 1 (quad).
module planar_element_shape_functions (
  input  logic        clk,
  input  logic        rst,
  pesf_point_if.sink  point,
  pesf_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pesf_pkg::*;

  logic [ET_W-1:0] element_type;
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  pt_ent_t         f_ent;
  pt_ent_t         head;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-ET_W){1'b0}}, element_type} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type <= ET_QUAD4;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      element_type <= pwdata[ET_W-1:0];
    end
  end

  pesf_front u_front (
    .clk, .rst, .point, .element_type, .q_full, .push, .ent(f_ent)
  );

  pesf_fifo u_fifo (
    .clk, .rst, .push, .wdata(f_ent), .full(q_full), .q_valid, .pop, .rdata(head)
  );

  pesf_back u_back (
    .clk, .rst, .q_valid, .head, .pop, .result
  );

  // The last node flag marks the element's final node.
  a_last_node: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last_node |->
      result.node_index == node_count(element_type) - NODE_W'(1))
    else $error("last_node on wrong node");

  // A linear triangle never clips.
  a_tri3_nosat: assert property (@(posedge clk) disable iff (rst)
    result.valid && element_type == ET_TRI3 |-> !result.saturated)
    else $error("three-node triangle result saturated");

  // Node numbers stay below the node count of the current element type.
  a_node_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.node_index < node_count(element_type))
    else $error("node index out of range");

endmodule

FILE: sim/planar_element_shape_functions_tb.sv
`timescale 1ns / 100ps

module planar_element_shape_functions_tb;
  import pesf_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [NODE_W-1:0]       node;
    logic signed [VAL_W-1:0] vals [NQ];
    logic                    sat;
    logic                    last;
  } node_result_t;

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
  } point_t;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pesf_point_if point ();
  pesf_result_if result ();

  planar_element_shape_functions DUT (
    .clk(clk), .rst(rst), .point(point.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  point_t pending_points [$];
  node_result_t expected_nodes [$];
  logic [ET_W-1:0] element_type = ET_QUAD4;
  int error_count = 0;
  int idle_cycles = 0;
  bit send_bursty = 1'b1;
  bit recv_bursty = 1'b1;
  int send_gap = 0;
  int recv_stall = 0;
  string field_names [NQ] = '{"shape_value", "d_dxi", "d2_dxi2", "d_deta", "d2_deta2",
                              "d2_dxi_deta"};
  logic [31:0] phase_types [6] = '{32'd1, 32'd0, 32'd2, 32'd3, 32'hFFFF_FFFD, 32'd1};

  // One-dimensional factor of kind k at derivative order d, over 2*U^2.
  function automatic longint factor_1d(logic [2:0] k, int d, longint x, longint u);
    case (k)
      K_LM: return d == 0 ? (u - x) * u : (d == 1 ? -u * u : 0);
      K_LP: return d == 0 ? (u + x) * u : (d == 1 ? u * u : 0);
      K_QM: return d == 0 ? x * (x - u) : (d == 1 ? (2 * x - u) * u : 2 * u * u);
      K_QZ: return d == 0 ? 2 * (u * u - x * x) : (d == 1 ? -4 * x * u : -4 * u * u);
      default: return d == 0 ? x * (x + u) : (d == 1 ? (2 * x + u) * u : 2 * u * u);
    endcase
  endfunction

  // Round half upward by sh bits, then clip to the result width.
  function automatic logic signed [VAL_W-1:0] round_clip(wide_t v, int sh, inout logic sat);
    wide_t r;
    r = (sh == 0) ? v : (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
    if (r > wide_t'(262143)) begin
      sat = 1'b1;
      return 19'sd262143;
    end
    if (r < -wide_t'(262144)) begin
      sat = 1'b1;
      return -19'sd262144;
    end
    return r[VAL_W-1:0];
  endfunction

  // Expected node results of one point for the current element type.
  function automatic void predict_nodes(logic signed [IN_W-1:0] xs, logic signed [IN_W-1:0] ys);
    longint x, y, u, kap, v, dx, dy;
    int count;
    wide_t q [NQ];
    int sh [NQ];
    logic [2:0] kx, ky;
    node_result_t e;
    int cxx [6] = '{4, 0, 4, 0, 0, -8};
    int cyy [6] = '{0, 4, 4, 0, -8, 0};
    int cxy [6] = '{0, 0, 4, 4, -4, -4};
    x = xs;
    y = ys;
    u = longint'(1) <<< FRAC;
    kap = u - x - y;
    count = (element_type == ET_TRI3) ? 3 : (element_type == ET_QUAD4) ? 4 :
            (element_type == ET_TRI6) ? 6 : 9;
    for (int n = 0; n < count; n++) begin
      for (int j = 0; j < NQ; j++) begin
        q[j] = '0;
        sh[j] = 0;
      end
      if (element_type == ET_TRI3) begin
        q[0] = wide_t'((n == 0) ? kap : (n == 1) ? x : y);
        q[1] = wide_t'((n == 0) ? -u : (n == 1) ? u : 0);
        q[3] = wide_t'((n == 0) ? -u : (n == 2) ? u : 0);
      end else if (element_type == ET_TRI6) begin
        case (n)
          0: begin v = x * (2 * x - u); dx = 4 * x - u; dy = 0; end
          1: begin v = y * (2 * y - u); dx = 0; dy = 4 * y - u; end
          2: begin v = kap * (2 * kap - u); dx = u - 4 * kap; dy = u - 4 * kap; end
          3: begin v = 4 * x * y; dx = 4 * y; dy = 4 * x; end
          4: begin v = 4 * y * kap; dx = -4 * y; dy = 4 * (kap - y); end
          default: begin v = 4 * kap * x; dx = 4 * (kap - x); dy = -4 * x; end
        endcase
        q[0] = wide_t'(v);
        sh[0] = FRAC;
        q[1] = wide_t'(dx);
        q[2] = wide_t'(cxx[n] * u);
        q[3] = wide_t'(dy);
        q[4] = wide_t'(cyy[n] * u);
        q[5] = wide_t'(cxy[n] * u);
      end else begin
        kx = (element_type == ET_QUAD4) ? QUAD4_KX[n] : QUAD9_KX[n];
        ky = (element_type == ET_QUAD4) ? QUAD4_KY[n] : QUAD9_KY[n];
        q[0] = wide_t'(factor_1d(kx, 0, x, u)) * wide_t'(factor_1d(ky, 0, y, u));
        q[1] = wide_t'(factor_1d(kx, 1, x, u)) * wide_t'(factor_1d(ky, 0, y, u));
        q[2] = wide_t'(factor_1d(kx, 2, x, u)) * wide_t'(factor_1d(ky, 0, y, u));
        q[3] = wide_t'(factor_1d(kx, 0, x, u)) * wide_t'(factor_1d(ky, 1, y, u));
        q[4] = wide_t'(factor_1d(kx, 0, x, u)) * wide_t'(factor_1d(ky, 2, y, u));
        q[5] = wide_t'(factor_1d(kx, 1, x, u)) * wide_t'(factor_1d(ky, 1, y, u));
        for (int j = 0; j < NQ; j++) sh[j] = 3 * FRAC + 2;
      end
      e.node = NODE_W'(n);
      e.sat = 1'b0;
      for (int j = 0; j < NQ; j++) e.vals[j] = round_clip(q[j], sh[j], e.sat);
      e.last = (n == count - 1);
      expected_nodes = {expected_nodes, e};
    end
  endfunction

  function automatic int draw_wait(bit bursty);
    return bursty ? 0 : $urandom_range(0, 11);
  endfunction

  // Point driver: holds each point until its transfer, then waits a random gap.
  always @(posedge clk) begin
    point_t p;
    if (rst) begin
      point.valid <= 1'b0;
      point.xi <= '0;
      point.eta <= '0;
    end else begin
      if (point.valid && point.ready) predict_nodes(point.xi, point.eta);
      if (!(point.valid && !point.ready)) begin
        if (send_gap != 0) begin
          point.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_points.size() != 0) begin
          p = pending_points.pop_front();
          point.xi <= p.x;
          point.eta <= p.y;
          point.valid <= 1'b1;
          if ($urandom_range(0, 15) == 0) send_bursty = ~send_bursty;
          send_gap <= draw_wait(send_bursty);
        end else begin
          point.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation.
  always @(posedge clk) begin
    node_result_t e;
    logic signed [VAL_W-1:0] got [NQ];
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{result.shape_value, result.d_dxi, result.d2_dxi2, result.d_deta,
                result.d2_deta2, result.d2_dxi_deta};
        if (expected_nodes.size() == 0) begin
          $error("node result with nothing expected: node_index %0d", result.node_index);
          error_count++;
        end else begin
          e = expected_nodes.pop_front();
          if (result.node_index !== e.node) begin
            $error("node_index expected %0d got %0d", e.node, result.node_index);
            error_count++;
          end
          for (int j = 0; j < NQ; j++)
            if (got[j] !== e.vals[j]) begin
              $error("%s expected %0d got %0d", field_names[j], e.vals[j], got[j]);
              error_count++;
            end
          if (result.saturated !== e.sat) begin
            $error("saturated expected %0b got %0b", e.sat, result.saturated);
            error_count++;
          end
          if (result.last_node !== e.last) begin
            $error("last_node expected %0b got %0b", e.last, result.last_node);
            error_count++;
          end
        end
      end
      if (recv_stall != 0) begin
        result.ready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        result.ready <= 1'b1;
        if (result.valid && result.ready) begin
          if ($urandom_range(0, 15) == 0) recv_bursty = ~recv_bursty;
          recv_stall <= draw_wait(recv_bursty);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((point.valid && point.ready) || (result.valid && result.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_element_type(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    element_type = value[ET_W-1:0];
  endtask

  task automatic add_point(int x, int y);
    point_t p;
    p.x = IN_W'(x);
    p.y = IN_W'(y);
    pending_points = {pending_points, p};
  endtask

  // Wait on settled values until every point has been sent and checked.
  task automatic drain();
    do @(negedge clk);
    while (pending_points.size() != 0 || point.valid || expected_nodes.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  // Stimulus: each element type in turn, directed corners (first four phases) then random points.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (phase_types[i]) begin
      write_element_type(phase_types[i]);
      if (i < 4) begin
        add_point(-16384, -16384);
        add_point(16384, 16384);
        add_point(16384, -16384);
        add_point(0, 0);
        add_point(8192, 8192);
        add_point(-32768, -32768);
        add_point(32767, 32767);
        add_point(-32768, 32767);
        add_point(1, -1);
        add_point(-1, 1);
        add_point(16384, 0);
        add_point(0, 16384);
      end
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 4) == 0)
          add_point($urandom_range(0, 65535), $urandom_range(0, 65535));
        else
          add_point(int'($urandom_range(0, 32768)) - 16384,
                    int'($urandom_range(0, 32768)) - 16384);
      end
      drain();
    end
    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: planar_element_shape_functions.f
rtl/pesf_pkg.sv
rtl/pesf_ifs.sv
rtl/pesf_front.sv
rtl/pesf_fifo.sv
rtl/pesf_back.sv
rtl/planar_element_shape_functions.sv
sim/planar_element_shape_functions_tb.sv
